/* design/mit_offtarget_local_score_defines.svh */
// Assertion macros shared by the local score block.
`ifndef MIT_OFFTARGET_LOCAL_SCORE_DEFINES_SVH
`define MIT_OFFTARGET_LOCAL_SCORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define MOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mos_pkg.sv */
package mos_pkg;

  // Field widths
  localparam int unsigned SIG_W         = 40;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned SCORE_W       = 23;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned POSITIONS_DEF = 20;

  // Fixed-point datapath widths
  localparam int unsigned MUL_W      = 17;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned T1_W       = 17;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned MSQ_W      = 9;
  localparam int unsigned BASE_W     = 11;
  localparam int unsigned DEN_W      = 20;
  localparam int unsigned DIVIDEND_W = NUM_W + 2;
  localparam int unsigned DIVISOR_W  = DEN_W + 1;

  // Constants of the score formula
  localparam logic [T1_W-1:0]    ONE_Q16    = 17'd65536;
  localparam logic [PROD_W-1:0]  HALF_Q16   = 34'd32768;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 23'd6553600;
  localparam logic [MUL_W-1:0]   NUM_K      = 17'd1900;   // 100 * 19
  localparam logic [BASE_W-1:0]  GAP_BASE_K = 11'd95;     // 19 * 5
  localparam logic [BASE_W-1:0]  SINGLE_K   = 11'd19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NUM,
    ST_MSQ,
    ST_DEN,
    ST_DIV,
    ST_WAIT,
    ST_FINISH
  } mos_state_e;

  // Mismatch factor 1 - penalty[pos] in Q1.16 (penalty in Q0.16)
  function automatic logic [MUL_W-1:0] pen_factor(input logic [LEN_W-1:0] pos);
    logic [15:0] pen;
    case (pos)
      5'd2:    pen = 16'd918;
      5'd5:    pen = 16'd25887;
      5'd6:    pen = 16'd20775;
      5'd8:    pen = 16'd25494;
      5'd9:    pen = 16'd5177;
      5'd10:   pen = 16'd29164;
      5'd11:   pen = 16'd33292;
      5'd12:   pen = 16'd40174;
      5'd13:   pen = 16'd55771;
      5'd14:   pen = 16'd47972;
      5'd15:   pen = 16'd54264;
      5'd16:   pen = 16'd40305;
      5'd17:   pen = 16'd52691;
      5'd18:   pen = 16'd44892;
      5'd19:   pen = 16'd38207;
      default: pen = 16'd0;
    endcase
    return ONE_Q16 - MUL_W'(pen);
  endfunction

endpackage

/* design/mit_offtarget_local_score.sv */
// Local off-target score of a guide pair from the XOR of its 2-bit signatures.
// Input channel: in_valid_i / in_stall_o carry one 40-bit xor_signature beat.
// Output channel: out_valid_o / out_stall_i carry score_q16 (unsigned Q7.16)
// and mismatch_count. seq_length is written through seq_length_we_i; the user
// must write it only while idle, the block itself does not enforce this.
// Each beat is scanned over min(seq_length, POSITIONS) positions, one per cycle,
// through a shared multiplier, which then forms the numerator, the squared
// mismatch count and the denominator; ST_DIV starts the restoring divider,
// which forms the SCORE_W quotient bits MSB first and raises its done flag.
// With no mismatch the result is loaded straight after the scan. The next beat
// can be taken in the cycle after the load. One item is in flight at a time:
// in_stall_o is high from the accepting edge until the result is loaded. A
// finished result sits in the output register while the next beat is accepted;
// if the receiver stalls, the following result waits in the block until the
// register frees up. Reset empties the output register, returns the sequencer
// to idle and sets seq_length to 20.
`include "mit_offtarget_local_score_defines.svh"

module mit_offtarget_local_score
  import mos_pkg::*;
#(
  parameter int unsigned POSITIONS = POSITIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               seq_length_we_i,
  input  logic [LEN_W-1:0]   seq_length_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SIG_W-1:0]   xor_signature_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SCORE_W-1:0] score_q16_o,
  output logic [COUNT_W-1:0] mismatch_count_o
);

  localparam int unsigned SIGR_W = 2 * POSITIONS;
  localparam int unsigned CNT_W  = $clog2(POSITIONS + 1);

  mos_state_e state_q, state_d;

  logic [LEN_W-1:0]   seq_len_q;
  logic [SIGR_W-1:0]  sig_q, sig_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   m_q, m_d;
  logic [CNT_W-1:0]   first_q, first_d;
  logic [CNT_W-1:0]   last_q, last_d;
  logic [T1_W-1:0]    t1_q, t1_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [MSQ_W-1:0]   msq_q, msq_d;
  logic [DEN_W-1:0]   den_q, den_d;

  logic               out_valid_q;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [COUNT_W-1:0] count_q;
  logic               out_load;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic               mul_rnd;
  logic [PROD_W-1:0]  prod;

  logic               div_start;
  logic               div_done;
  logic [SCORE_W-1:0] quotient;

  logic [LEN_W-1:0]   len_clamped;
  logic [COUNT_W-1:0] m5;
  logic [COUNT_W-1:0] span;
  logic [MUL_W-1:0]   num_k;
  logic [BASE_W-1:0]  den_base;
  logic               mis;
  logic [CNT_W-1:0]   pos_inc;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= LEN_W'(20);
    end else if (seq_length_we_i) begin
      seq_len_q <= seq_length_i;
    end
  end

  // Operand terms for the T2/T3 stage
  assign len_clamped = (seq_len_q > LEN_W'(POSITIONS)) ? LEN_W'(POSITIONS) : seq_len_q;
  assign m5          = COUNT_W'(m_q);
  assign span        = COUNT_W'(last_q - first_q);
  assign num_k       = (m5 == COUNT_W'(1)) ? NUM_K : MUL_W'(m5 - COUNT_W'(1)) * NUM_K;
  assign den_base    = (m5 == COUNT_W'(1)) ? SINGLE_K
                     : BASE_W'(m5 - COUNT_W'(1)) * GAP_BASE_K - BASE_W'({span, 2'b00});
  assign mis         = sig_q[1:0] != 2'b00;
  assign pos_inc     = pos_q + CNT_W'(1);

  mos_mul u_mul (
    .a_i    (mul_a),
    .b_i    (mul_b),
    .rnd_i  (mul_rnd),
    .prod_o (prod)
  );

  mos_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({num_q, 1'b0} + DIVIDEND_W'(den_q)),
    .divisor_i  ({den_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output register loads when empty or being drained
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign score_d  = (m_q == '0) ? '0 : ((quotient > SCORE_MAX) ? SCORE_MAX : quotient);

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d   = state_q;
    sig_d     = sig_q;
    len_d     = len_q;
    pos_d     = pos_q;
    m_d       = m_q;
    first_d   = first_q;
    last_d    = last_q;
    t1_d      = t1_q;
    num_d     = num_q;
    msq_d     = msq_q;
    den_d     = den_q;
    mul_a     = t1_q;
    mul_b     = pen_factor(LEN_W'(pos_q));
    mul_rnd   = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sig_d   = xor_signature_i[SIGR_W-1:0];
          len_d   = CNT_W'(len_clamped);
          pos_d   = '0;
          m_d     = '0;
          first_d = '0;
          last_d  = '0;
          t1_d    = ONE_Q16;
          state_d = (len_clamped == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        mul_rnd = 1'b1;
        if (mis) begin
          t1_d   = prod[T1_W+15:16];
          m_d    = m_q + CNT_W'(1);
          last_d = pos_q;
          if (m_q == '0) begin
            first_d = pos_q;
          end
        end
        sig_d = sig_q >> 2;
        pos_d = pos_inc;
        if (pos_inc == len_q) begin
          state_d = (m_d == '0) ? ST_FINISH : ST_NUM;
        end
      end
      ST_NUM: begin
        // 100 * T1 * 19(m-1), or 100 * T1 * 19 when m = 1
        mul_b   = num_k;
        num_d   = prod[NUM_W-1:0];
        state_d = ST_MSQ;
      end
      ST_MSQ: begin
        mul_a   = MUL_W'(m5);
        mul_b   = MUL_W'(m5);
        msq_d   = prod[MSQ_W-1:0];
        state_d = ST_DEN;
      end
      ST_DEN: begin
        // (95(m-1) - 4s) * m^2, or 19 * m^2 when m = 1
        mul_a   = MUL_W'(den_base);
        mul_b   = MUL_W'(msq_q);
        den_d   = prod[DEN_W-1:0];
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sig_q   <= sig_d;
    len_q   <= len_d;
    pos_q   <= pos_d;
    m_q     <= m_d;
    first_q <= first_d;
    last_q  <= last_d;
    t1_q    <= t1_d;
    num_q   <= num_d;
    msq_q   <= msq_d;
    den_q   <= den_d;
    if (out_load) begin
      score_q <= score_d;
      count_q <= COUNT_W'(m_q);
    end
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign score_q16_o      = score_q;
  assign mismatch_count_o = count_q;

  `MOS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no stall after accept")
  `MOS_ASSERT(a_score_sat, out_valid_o |-> score_q16_o <= SCORE_MAX, "score above saturation")
  `MOS_ASSERT(a_zero_score, out_valid_o && mismatch_count_o == '0 |-> score_q16_o == '0, "nonzero score with no mismatch")
  `MOS_ASSERT(a_count_bound, state_q == ST_SCAN |-> m_q <= pos_q, "mismatch count above scanned positions")
  `MOS_ASSERT_NEXT(a_div_started, state_q == ST_DIV, state_q == ST_WAIT, "divider start not followed by wait")

endmodule

/* design/mos_mul.sv */
// Shared multiplier with optional Q0.16 round-half-up offset.
module mos_mul
  import mos_pkg::*;
(
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  input  logic              rnd_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_raw;

  assign prod_raw = PROD_W'(a_i) * PROD_W'(b_i);
  assign prod_o   = rnd_i ? prod_raw + HALF_Q16 : prod_raw;

endmodule

/* design/mos_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient must fit in SCORE_W bits.
module mos_div
  import mos_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [SCORE_W-1:0]    quotient_o
);

  localparam int unsigned DSH_W = DIVISOR_W + SCORE_W - 1;
  localparam int unsigned CNT_W = $clog2(SCORE_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] rem_q, rem_d;
  logic [DSH_W-1:0]      dsh_q, dsh_d;
  logic [SCORE_W-1:0]    quo_q, quo_d;
  logic [DSH_W-1:0]      rem_ext;
  logic                  fits;

  assign rem_ext = DSH_W'(rem_q);
  assign fits    = rem_ext >= dsh_q;

  // One compare-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i;
      dsh_d  = {divisor_i, {(SCORE_W-1){1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DIVIDEND_W'(rem_ext - dsh_q);
      end
      quo_d = {quo_q[SCORE_W-2:0], fits};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(SCORE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
